// ===== design/mdsd_pkg.sv =====
// ----------------------------------------------------------------------------
// mdsd_pkg
// Shared types and constants of the motor deadzone smoothstep drive.
// ----------------------------------------------------------------------------
package mdsd_pkg;

  // default parameter values
  localparam int DUTY_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  // register field widths
  localparam int DZ_W       = 12;
  localparam int RW_W       = 15;
  localparam int PWM_W      = 15;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_IDX_W  = 3;

  // register reset values
  localparam logic [DZ_W-1:0]  DZ_RST  = '0;
  localparam logic [RW_W-1:0]  RW_RST  = 15'd1;
  localparam logic [PWM_W-1:0] PWM_RST = 15'd10000;

  // lane stages beyond the divider: input, square, scale, deadzone product, clamp
  localparam int LANE_EXTRA_STAGES = 5;

  localparam int OUT_TDATA_W = ((2 * (1 + PWM_W) + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DZ_LEFT  = 3'd0,
    REG_DZ_RIGHT = 3'd1,
    REG_RAMP     = 3'd2,
    REG_MAX_PWM  = 3'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [RW_W-1:0]  ramp_span;
    logic [PWM_W-1:0] max_pwm;
  } lane_cfg_t;

  typedef struct packed {
    logic             dir;
    logic [PWM_W-1:0] mag;
  } lane_res_t;

  typedef struct packed {
    lane_res_t right;
    lane_res_t left;
  } out_res_t;

endpackage

// ===== design/mdsd_lane.sv =====
// ----------------------------------------------------------------------------
// mdsd_lane
// One wheel: ramp fraction by a bit-per-stage divider, smoothstep scale,
// deadzone boost, clamp and split into direction and magnitude.
// ----------------------------------------------------------------------------
module mdsd_lane #(
  parameter int DUTY_WIDTH = mdsd_pkg::DUTY_WIDTH_DEF,
  parameter int FRAC_BITS  = mdsd_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [DUTY_WIDTH-1:0]     duty_i,
  input  logic [mdsd_pkg::DZ_W-1:0] dz_i,
  input  mdsd_pkg::lane_cfg_t       cfg_i,
  output mdsd_pkg::lane_res_t       res_o
);
  import mdsd_pkg::*;

  localparam int CW    = (DUTY_WIDTH > RW_W) ? DUTY_WIDTH : RW_W;
  localparam int BW    = CW + 1;
  localparam int QW    = FRAC_BITS + 1;
  localparam int KW    = FRAC_BITS + 2;
  localparam int SW    = DZ_W + QW + 1;
  localparam int DEPTH = FRAC_BITS + 4;

  localparam logic [QW-1:0] ONE_Q   = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [KW-1:0] THREE_Q = {2'b11, {FRAC_BITS{1'b0}}};
  localparam logic [SW-1:0] HALF_Q  = SW'(1) << (FRAC_BITS - 1);

  logic [RW_W-1:0]       rw_eff;
  logic                  neg;
  logic [DUTY_WIDTH-1:0] mag_in;
  logic [CW-1:0]         mag_ext;
  logic                  sat;

  // carried along the whole lane
  logic [DUTY_WIDTH-1:0] a_q   [DEPTH];
  logic                  neg_q [DEPTH];
  // divider state, stage 0 is the input register
  logic [RW_W-1:0]       rem_q [FRAC_BITS+1];
  logic [FRAC_BITS-1:0]  quo_q [FRAC_BITS+1];
  logic                  sat_q [FRAC_BITS+1];

  logic [QW-1:0]      t_val;
  logic [2*QW-1:0]    t_sq;
  logic [QW-1:0]      t2_q;
  logic [KW-1:0]      k_q;
  logic [QW+KW-1:0]   scale_prod;
  logic [QW-1:0]      scale_q;
  logic [DZ_W+QW-1:0] dz_prod;
  logic [SW-1:0]      dz_sum;
  logic [DZ_W-1:0]    comp_q;
  logic [BW-1:0]      boosted;
  logic [BW-1:0]      limit;
  logic [BW-1:0]      clipped;
  lane_res_t          res_q;

  assign rw_eff  = (cfg_i.ramp_span == '0) ? RW_W'(1) : cfg_i.ramp_span;
  assign neg     = duty_i[DUTY_WIDTH-1];
  assign mag_in  = neg ? (~duty_i + DUTY_WIDTH'(1)) : duty_i;
  assign mag_ext = CW'(mag_in);
  assign sat     = mag_ext >= CW'(rw_eff);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q[0]   <= mag_in;
      neg_q[0] <= neg;
      sat_q[0] <= sat;
      rem_q[0] <= sat ? '0 : mag_ext[RW_W-1:0];
      quo_q[0] <= '0;
    end
  end

  for (genvar i = 1; i < DEPTH; i++) begin : g_carry
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[i]   <= a_q[i-1];
        neg_q[i] <= neg_q[i-1];
      end
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar i = 1; i <= FRAC_BITS; i++) begin : g_div
    logic [RW_W:0] rem_sh;
    logic [RW_W:0] rem_sub;
    logic          ge;
    assign rem_sh  = {rem_q[i-1], 1'b0};
    assign rem_sub = rem_sh - {1'b0, rw_eff};
    assign ge      = rem_sh >= {1'b0, rw_eff};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= ge ? rem_sub[RW_W-1:0] : rem_sh[RW_W-1:0];
        quo_q[i] <= {quo_q[i-1][FRAC_BITS-2:0], ge};
        sat_q[i] <= sat_q[i-1];
      end
    end
  end

  assign t_val      = sat_q[FRAC_BITS] ? ONE_Q : {1'b0, quo_q[FRAC_BITS]};
  assign t_sq       = t_val * t_val;
  assign scale_prod = t2_q * k_q;
  assign dz_prod    = dz_i * scale_q;
  assign dz_sum     = SW'(dz_prod) + HALF_Q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t2_q    <= t_sq[2*FRAC_BITS:FRAC_BITS];
      k_q     <= THREE_Q - {t_val, 1'b0};
      scale_q <= scale_prod[2*FRAC_BITS:FRAC_BITS];
      comp_q  <= dz_sum[FRAC_BITS+DZ_W-1:FRAC_BITS];
    end
  end

  assign boosted = BW'(a_q[DEPTH-1]) + BW'(comp_q);
  assign limit   = BW'(cfg_i.max_pwm);
  assign clipped = (boosted > limit) ? limit : boosted;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.dir <= (clipped == '0) ? 1'b1 : ~neg_q[DEPTH-1];
      res_q.mag <= clipped[PWM_W-1:0];
    end
  end

  assign res_o = res_q;

endmodule

// ===== design/mdsd_out_buf.sv =====
// ----------------------------------------------------------------------------
// mdsd_out_buf
// Output register with a skid stage; stalls the lanes only when both are full.
// ----------------------------------------------------------------------------
module mdsd_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  mdsd_pkg::out_res_t data_i,
  output logic               en_o,
  output logic               valid_o,
  input  logic               ready_i,
  output mdsd_pkg::out_res_t data_o
);
  import mdsd_pkg::*;

  logic     out_valid_q;
  logic     skid_q;
  out_res_t out_q;
  out_res_t skid_data_q;
  logic     push;

  assign en_o = ~skid_q;
  assign push = valid_i & ~skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_q      <= 1'b0;
    end else if (!out_valid_q || ready_i) begin
      out_valid_q <= skid_q | push;
      skid_q      <= 1'b0;
    end else if (push) begin
      skid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || ready_i) begin
      out_q <= skid_q ? skid_data_q : data_i;
    end else if (push) begin
      skid_data_q <= data_i;
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_q |-> out_valid_q)
    else $error("skid holds a beat while the output register is empty");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_q && ready_i) |=> !skid_q)
    else $error("skid did not drain after the output beat was taken");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_q) |-> $past(out_valid_q && !ready_i))
    else $error("skid filled without an output stall");
`endif

endmodule

// ===== design/motor_deadzone_smoothstep_drive.sv =====
// ----------------------------------------------------------------------------
// motor_deadzone_smoothstep_drive
// Two-wheel smooth deadzone compensation with saturation and sign split.
// ----------------------------------------------------------------------------
// Takes one beat per clock, carrying a signed duty request for each wheel, and
// returns one beat per input beat with direction and magnitude per wheel, in
// order. Both wheels run in their own lane side by side, each lane a pipeline
// of registers from the input beat to the output beat, in which
// the ramp fraction comes from a restoring divider that resolves one quotient
// bit per pipeline stage, followed by the square, the smoothstep scale, the
// deadzone product, the clamp and the output register. Throughput is one item
// per cycle; while the output stalls the lanes keep moving until a beat lands
// in the skid stage, and only then is the input held off.
// Registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i and must
// only be changed while no beat is in flight.
module motor_deadzone_smoothstep_drive #(
  parameter int DUTY_WIDTH = mdsd_pkg::DUTY_WIDTH_DEF,
  parameter int FRAC_BITS  = mdsd_pkg::FRAC_BITS_DEF,
  localparam int InTdataW  = ((2 * DUTY_WIDTH + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mdsd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mdsd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // duty_left, duty_right
  input  logic [InTdataW-1:0]             s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // dir_left, mag_left, dir_right, mag_right
  output logic [mdsd_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);
  import mdsd_pkg::*;

  localparam int LAT = FRAC_BITS + LANE_EXTRA_STAGES;

  logic [DZ_W-1:0]  dz_left_q;
  logic [DZ_W-1:0]  dz_right_q;
  logic [RW_W-1:0]  ramp_q;
  logic [PWM_W-1:0] max_pwm_q;
  lane_cfg_t        lane_cfg;

  logic             en;
  logic [LAT-1:0]   vld_q;
  lane_res_t        res_left;
  lane_res_t        res_right;
  out_res_t         merged;
  out_res_t         out_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_left_q  <= DZ_RST;
      dz_right_q <= DZ_RST;
      ramp_q     <= RW_RST;
      max_pwm_q  <= PWM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DZ_LEFT:  dz_left_q  <= cfg_wdata_i[DZ_W-1:0];
        REG_DZ_RIGHT: dz_right_q <= cfg_wdata_i[DZ_W-1:0];
        REG_RAMP:     ramp_q     <= cfg_wdata_i[RW_W-1:0];
        REG_MAX_PWM:  max_pwm_q  <= cfg_wdata_i[PWM_W-1:0];
        default: ;
      endcase
    end
  end

  assign lane_cfg.ramp_span = ramp_q;
  assign lane_cfg.max_pwm   = max_pwm_q;

  assign s_axis_tready_o = en;

  // beat valid flags travel alongside the lane stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid_i};
    end
  end

  mdsd_lane #(
    .DUTY_WIDTH (DUTY_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_lane_left (
    .clk_i  (clk_i),
    .en_i   (en),
    .duty_i (s_axis_tdata_i[DUTY_WIDTH-1:0]),
    .dz_i   (dz_left_q),
    .cfg_i  (lane_cfg),
    .res_o  (res_left)
  );

  mdsd_lane #(
    .DUTY_WIDTH (DUTY_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_lane_right (
    .clk_i  (clk_i),
    .en_i   (en),
    .duty_i (s_axis_tdata_i[2*DUTY_WIDTH-1:DUTY_WIDTH]),
    .dz_i   (dz_right_q),
    .cfg_i  (lane_cfg),
    .res_o  (res_right)
  );

  assign merged.left  = res_left;
  assign merged.right = res_right;

  mdsd_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q[LAT-1]),
    .data_i  (merged),
    .en_o    (en),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (out_data)
  );

  assign m_axis_tdata_o = OUT_TDATA_W'({out_data.right.mag, out_data.right.dir,
                                        out_data.left.mag, out_data.left.dir});

`ifndef SYNTH
  a_mag_within_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[LAT-1] |-> (res_left.mag <= max_pwm_q && res_right.mag <= max_pwm_q))
    else $error("lane magnitude above the saturation limit");

  a_reverse_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[LAT-1] |-> ((res_left.dir || res_left.mag != '0) &&
                      (res_right.dir || res_right.mag != '0)))
    else $error("reverse direction with zero magnitude");

  a_zero_limit_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[LAT-1] && max_pwm_q == '0) |-> (res_left.dir && res_right.dir))
    else $error("zero limit must give forward direction");
`endif

endmodule

// ===== tb/tb_motor_deadzone_smoothstep_drive.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_motor_deadzone_smoothstep_drive
// Self-checking bench for the two-wheel smooth deadzone drive.
// ----------------------------------------------------------------------------
// Duty pairs go in on the slave stream. A local fixed-point model of the
// smoothstep boost, clamp and sign split predicts each output beat, and the
// predictions are compared in order against the master stream. Directed
// tests cover the register extremes, the ramp edges, the clamp, a zero ramp,
// masked and out-of-range register writes. They are followed by random
// phases that use their own register settings and different mixes of
// sender gaps and receiver stalls.
module tb_motor_deadzone_smoothstep_drive;
  import mdsd_pkg::*;

  localparam int FRAC       = FRAC_BITS_DEF;
  localparam int DUTY_W     = DUTY_WIDTH_DEF;
  localparam int IN_W       = ((2 * DUTY_W + 7) / 8) * 8;
  localparam int PIPE_DEPTH = FRAC + LANE_EXTRA_STAGES + 1;
  localparam int QUIET_MAX  = 4000;
  localparam longint unsigned UNIT = 64'd1 << FRAC;

  typedef struct packed {
    logic             dir;
    logic [PWM_W-1:0] mag;
  } wheel_cmd_t;

  typedef struct packed {
    wheel_cmd_t left;
    wheel_cmd_t right;
  } wheel_pair_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_W-1:0]        s_axis_tdata_i = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  // register shadow for prediction
  logic [DZ_W-1:0]  cfg_dz_left  = DZ_RST;
  logic [DZ_W-1:0]  cfg_dz_right = DZ_RST;
  logic [RW_W-1:0]  cfg_ramp     = RW_RST;
  logic [PWM_W-1:0] cfg_max_pwm  = PWM_RST;

  wheel_pair_t pending_cmds[$];
  wheel_pair_t want_pair;
  wheel_pair_t got_pair;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          snd_idle_pct = 0;
  int          rcv_stall_pct = 0;

  motor_deadzone_smoothstep_drive dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #1 clk_i = ~clk_i;

  // smoothstep boost of one wheel, clamp and sign split
  function automatic wheel_cmd_t boost_wheel(logic [DUTY_W-1:0] duty, logic [DZ_W-1:0] dz);
    wheel_cmd_t res;
    logic neg;
    longint unsigned mag_in, span, frac, frac_sq, shape, boost, total;
    neg    = duty[DUTY_W-1];
    mag_in = neg ? (64'd1 << DUTY_W) - duty : duty;
    res.dir = 1'b1;
    res.mag = '0;
    if (mag_in == 0) return res;
    span = (cfg_ramp == 0) ? 1 : cfg_ramp;
    frac = (mag_in << FRAC) / span;
    if (frac > UNIT) frac = UNIT;
    frac_sq = (frac * frac) >> FRAC;
    shape   = (frac_sq * (3 * UNIT - 2 * frac)) >> FRAC;
    boost   = (dz * shape + (UNIT >> 1)) >> FRAC;
    total   = mag_in + boost;
    if (total > cfg_max_pwm) total = cfg_max_pwm;
    if (total != 0) begin
      res.dir = ~neg;
      res.mag = total[PWM_W-1:0];
    end
    return res;
  endfunction

  task automatic note_mismatch(string what, int got, int want);
    mismatches++;
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  // receiver backpressure
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= rcv_stall_pct);
  end

  // output beat checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_pair.left.dir  = m_axis_tdata_o[0];
      got_pair.left.mag  = m_axis_tdata_o[PWM_W:1];
      got_pair.right.dir = m_axis_tdata_o[PWM_W+1];
      got_pair.right.mag = m_axis_tdata_o[2*PWM_W+1:PWM_W+2];
      if (pending_cmds.size() == 0) begin
        note_mismatch("beat with nothing pending", int'(m_axis_tdata_o), -1);
      end else begin
        want_pair = pending_cmds.pop_front();
        if (got_pair.left.dir !== want_pair.left.dir)
          note_mismatch("dir_left", got_pair.left.dir, want_pair.left.dir);
        if (got_pair.left.mag !== want_pair.left.mag)
          note_mismatch("mag_left", got_pair.left.mag, want_pair.left.mag);
        if (got_pair.right.dir !== want_pair.right.dir)
          note_mismatch("dir_right", got_pair.right.dir, want_pair.right.dir);
        if (got_pair.right.mag !== want_pair.right.mag)
          note_mismatch("mag_right", got_pair.right.mag, want_pair.right.mag);
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_duty(logic [DUTY_W-1:0] left, logic [DUTY_W-1:0] right);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= IN_W'($urandom);
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {right, left};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_cmds.push_back({boost_wheel(left, cfg_dz_left), boost_wheel(right, cfg_dz_right)});
    @(negedge clk_i);
  endtask

  // stop sending and wait for every predicted beat
  task automatic settle_outputs();
    s_axis_tvalid_i <= 1'b0;
    do @(negedge clk_i); while (pending_cmds.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_DZ_LEFT:  cfg_dz_left  = value[DZ_W-1:0];
      REG_DZ_RIGHT: cfg_dz_right = value[DZ_W-1:0];
      REG_RAMP:     cfg_ramp     = value[RW_W-1:0];
      REG_MAX_PWM:  cfg_max_pwm  = value[PWM_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic load_setup(int dz_l, int dz_r, int ramp, int max_pwm);
    write_reg(REG_DZ_LEFT, CFG_DATA_W'(dz_l));
    write_reg(REG_DZ_RIGHT, CFG_DATA_W'(dz_r));
    write_reg(REG_RAMP, CFG_DATA_W'(ramp));
    write_reg(REG_MAX_PWM, CFG_DATA_W'(max_pwm));
  endtask

  function automatic logic [DUTY_W-1:0] pick_duty();
    int m;
    int reach;
    reach = 2 * int'(cfg_ramp);
    if (reach > 32768) reach = 32768;
    case ($urandom_range(9))
      0, 1, 2, 3: m = $urandom_range(reach, 0);
      4, 5, 6:    return DUTY_W'($urandom);
      7:          return '0;
      8: begin
        case ($urandom_range(2))
          0:       m = 1;
          1:       m = 32767;
          default: m = 32768;
        endcase
      end
      default: m = $urandom_range(15, 0);
    endcase
    if (m == 32768) return {1'b1, {(DUTY_W-1){1'b0}}};
    return $urandom_range(1) ? DUTY_W'(m) : DUTY_W'(-m);
  endfunction

  task automatic pick_setup();
    int dz[2];
    int ramp, max_pwm;
    foreach (dz[k]) begin
      case ($urandom_range(3))
        0:       dz[k] = 0;
        1:       dz[k] = (1 << DZ_W) - 1;
        default: dz[k] = $urandom_range((1 << DZ_W) - 1, 0);
      endcase
    end
    case ($urandom_range(4))
      0:       ramp = 1;
      1:       ramp = (1 << RW_W) - 1;
      2:       ramp = $urandom_range(64, 1);
      3:       ramp = $urandom_range(2000, 1);
      default: ramp = $urandom_range((1 << RW_W) - 1, 1);
    endcase
    case ($urandom_range(7))
      0:       max_pwm = 0;
      1:       max_pwm = (1 << PWM_W) - 1;
      2:       max_pwm = $urandom_range(50, 0);
      default: max_pwm = $urandom_range((1 << PWM_W) - 1, 0);
    endcase
    load_setup(dz[0], dz[1], ramp, max_pwm);
  endtask

  // registers at reset: no boost, ramp of one, clamp at 10000
  task automatic test_reset_values();
    send_duty(16'sd0, 16'sd0);
    send_duty(16'sd1, -16'sd1);
    send_duty(16'sd32767, -16'sd32768);
    settle_outputs();
  endtask

  // largest deadzones and widest ramp, clamp at the top of the range
  task automatic test_full_boost();
    load_setup(4095, 4095, 32767, 32767);
    send_duty(16'sd32767, -16'sd32768);
    send_duty(-16'sd1, 16'sd1);
    send_duty(16'sd16384, -16'sd16384);
    send_duty(16'sd0, 16'sd32767);
    settle_outputs();
  endtask

  // duties just inside, at and beyond the ramp width
  task automatic test_ramp_edges();
    load_setup(100, 4095, 200, 10000);
    send_duty(16'sd199, -16'sd200);
    send_duty(16'sd200, 16'sd201);
    send_duty(-16'sd100, 16'sd100);
    send_duty(-16'sd201, 16'sd1);
    settle_outputs();
  endtask

  // zero clamp forces forward direction even for reverse requests
  task automatic test_clamp();
    load_setup(4095, 0, 50, 0);
    send_duty(-16'sd5, 16'sd5);
    send_duty(-16'sd32768, 16'sd0);
    settle_outputs();
    write_reg(REG_MAX_PWM, CFG_DATA_W'(1));
    send_duty(-16'sd1, 16'sd2);
    settle_outputs();
  endtask

  // zero ramp, too-wide deadzone values, writes to unused indexes
  task automatic test_odd_writes();
    load_setup(0, 0, 0, 32767);
    write_reg(REG_DZ_LEFT, '1);
    write_reg(REG_DZ_RIGHT, CFG_DATA_W'(1 << DZ_W) | CFG_DATA_W'(7));
    for (int k = REG_MAX_PWM + 1; k < (1 << CFG_IDX_W); k++)
      write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
    send_duty(16'sd1, -16'sd1);
    send_duty(16'sd3, -16'sd7);
    send_duty(-16'sd32768, 16'sd32767);
    settle_outputs();
  endtask

  task automatic test_random_mix();
    int snd_tab[4] = '{0, 70, 0, 23};
    int rcv_tab[4] = '{0, 0, 70, 23};
    for (int ph = 0; ph < 8; ph++) begin
      pick_setup();
      snd_idle_pct  = snd_tab[ph % 4];
      rcv_stall_pct = rcv_tab[ph % 4];
      for (int k = 0; k < 210; k++) begin
        send_duty(pick_duty(), pick_duty());
        // hold off until the pipe has drained
        if ((ph == 1 && k == 100) || $urandom_range(199) == 0)
          settle_outputs();
      end
      settle_outputs();
    end
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_values();
    test_full_boost();
    test_ramp_edges();
    test_clamp();
    test_odd_writes();
    test_random_mix();
    settle_outputs();
    repeat (2 * PIPE_DEPTH) @(negedge clk_i);
    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
